@@ design/ltfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfs_pkg
// Shared widths, reset values and defaults for the triangular forward solver.
// ----------------------------------------------------------------------------
package ltfs_pkg;

    localparam int COEF_W            = 32;   // Q16.16 operands
    localparam int ACC_W             = 64;   // Q32.32 accumulator
    localparam int CFG_W             = 7;    // system_order register
    localparam int ROW_OUT_W         = 6;    // row_number field
    localparam int DEFAULT_MAX_ORDER = 64;

    localparam logic [CFG_W-1:0] ORDER_RESET = 7'd64;

    localparam int IN_DATA_W  = 64;          // coefficient, rhs_value
    localparam int OUT_DATA_W = 40;          // solution, row_number, pad

    localparam logic [COEF_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [ACC_W-1:0]  A_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0]  A_MIN = 64'h8000_0000_0000_0000;

endpackage

@@ design/ltfs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfs_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ltfs_ram
    import ltfs_pkg::*;
#(
    parameter int WIDTH = COEF_W,
    parameter int DEPTH = DEFAULT_MAX_ORDER,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/lower_triangular_forward_solve_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lower_triangular_forward_solve_top
// Streaming forward substitution for L x = v in signed Q16.16.
// ----------------------------------------------------------------------------
// Below-diagonal coefficients are taken one per cycle: the earlier solution is
// read from the solution RAM at accept, multiplied the next cycle and added to
// the Q32.32 accumulator the cycle after, so a run of coefficients streams with
// no gaps. The diagonal transaction (tlast high) holds the input while the
// multiply-accumulate pipe drains, the numerator, magnitudes and range check
// are formed, the radix-2 divider produces the 32 quotient bits, and then
// sign/saturate and the write-back of x(i) into the RAM follow. A zero
// diagonal or a quotient out of range skips the divider and sign/saturate. The
// write-back waits while the previous result is still unaccepted on the
// output. The solution RAM needs no clearing pass after reset.
// Coefficients of the next row are accepted while the previous result still
// waits on the output.
// ----------------------------------------------------------------------------
module lower_triangular_forward_solve_top
    import ltfs_pkg::*;
#(
    parameter int MAX_ORDER = DEFAULT_MAX_ORDER
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: system_order
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] coefficient, [63:32] rhs_value
    input  logic                  s_axis_tlast,   // ends_row
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] solution, [37:32] row_number
    output logic                  m_axis_tuser,   // error_flag
    output logic                  m_axis_tlast    // last_row
);

    localparam int ROW_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int ORD_W  = ($clog2(MAX_ORDER + 1) > CFG_W) ? $clog2(MAX_ORDER + 1) : CFG_W;
    localparam int CNT_W  = $clog2(COEF_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_NUM   = 3'd2;
    localparam logic [2:0] ST_MAG   = 3'd3;
    localparam logic [2:0] ST_CHK   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_SIGN  = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [CFG_W-1:0]       order_reg;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [ROW_W-1:0]       col_reg, col_next;
    logic [ACC_W-1:0]       sum_reg, sum_next;
    logic                   sovf_reg, sovf_next;
    // multiply-accumulate pipe
    logic                   s1_valid_reg, s1_valid_next;
    logic [COEF_W-1:0]      s1_coef_reg, s1_coef_next;
    logic                   s2_valid_reg, s2_valid_next;
    logic [ACC_W-1:0]       prod_reg, prod_next;
    // diagonal path
    logic [COEF_W-1:0]      diag_reg, diag_next;
    logic [COEF_W-1:0]      rhs_reg, rhs_next;
    logic [ACC_W-1:0]       num_reg, num_next;
    logic                   err_reg, err_next;
    logic [ACC_W-1:0]       nmag_reg, nmag_next;
    logic [COEF_W-1:0]      dmag_reg, dmag_next;
    logic                   neg_reg, neg_next;
    logic                   dzero_reg, dzero_next;
    logic [COEF_W-1:0]      rem_reg, rem_next;
    logic [COEF_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COEF_W-1:0]      x_reg, x_next;
    // output register
    logic                   ov_reg, ov_next;
    logic [COEF_W-1:0]      osol_reg, osol_next;
    logic [ROW_OUT_W-1:0]   orow_reg, orow_next;
    logic                   oerr_reg, oerr_next;
    logic                   olast_reg, olast_next;

    logic                   in_acc;
    logic                   ram_we, ram_re;
    logic [COEF_W-1:0]      ram_rdata;

    logic [ORD_W-1:0]       ord_cfg, ord_eff, row_ext, row_inc;
    logic                   row_last;
    logic [ACC_W-1:0]       add_s, sub_d, rhs_q;
    logic [COEF_W:0]        div_t;
    logic                   div_ge;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b00, orow_reg, osol_reg};
    assign m_axis_tuser  = oerr_reg;
    assign m_axis_tlast  = olast_reg;

    // effective order: 0 acts as 1, above MAX_ORDER acts as MAX_ORDER
    assign ord_cfg  = ORD_W'(order_reg);
    assign ord_eff  = (ord_cfg == '0) ? ORD_W'(1) :
                      (ord_cfg > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ord_cfg;
    assign row_ext  = ORD_W'(row_reg);
    assign row_inc  = row_ext + ORD_W'(1);
    assign row_last = (row_inc >= ord_eff);

    assign add_s  = sum_reg + prod_reg;
    assign rhs_q  = {{(ACC_W-COEF_W-16){rhs_reg[COEF_W-1]}}, rhs_reg, 16'h0000};
    assign sub_d  = rhs_q - sum_reg;
    assign div_t  = {rem_reg, quo_reg[COEF_W-1]};
    assign div_ge = (div_t >= {1'b0, dmag_reg});

    assign ram_re = in_acc && !s_axis_tlast && (col_reg < row_reg);
    assign ram_we = (state_reg == ST_FIN) && (!ov_reg || m_axis_tready);

    ltfs_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_ORDER)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (row_reg),
        .wr_data (x_reg),
        .rd_en   (ram_re),
        .rd_addr (col_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        sum_next      = sum_reg;
        sovf_next     = sovf_reg;
        s1_valid_next = ram_re;
        s1_coef_next  = ram_re ? s_axis_tdata[COEF_W-1:0] : s1_coef_reg;
        s2_valid_next = s1_valid_reg;
        prod_next     = s1_valid_reg ? ACC_W'($signed(s1_coef_reg) * $signed(ram_rdata))
                                     : prod_reg;
        diag_next     = diag_reg;
        rhs_next      = rhs_reg;
        num_next      = num_reg;
        err_next      = err_reg;
        nmag_next     = nmag_reg;
        dmag_next     = dmag_reg;
        neg_next      = neg_reg;
        dzero_next    = dzero_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        x_next        = x_reg;
        ov_next       = ov_reg && !m_axis_tready;
        osol_next     = osol_reg;
        orow_next     = orow_reg;
        oerr_next     = oerr_reg;
        olast_next    = olast_reg;

        if (ram_re)
        begin
            col_next = col_reg + ROW_W'(1);
        end

        // saturating accumulate
        if (s2_valid_reg)
        begin
            if ((sum_reg[ACC_W-1] == prod_reg[ACC_W-1]) &&
                (add_s[ACC_W-1] != sum_reg[ACC_W-1]))
            begin
                sum_next  = sum_reg[ACC_W-1] ? A_MIN : A_MAX;
                sovf_next = 1'b1;
            end
            else
            begin
                sum_next = add_s;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    diag_next  = s_axis_tdata[COEF_W-1:0];
                    rhs_next   = s_axis_tdata[2*COEF_W-1:COEF_W];
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                err_next = sovf_reg;
                if ((rhs_q[ACC_W-1] != sum_reg[ACC_W-1]) &&
                    (sub_d[ACC_W-1] != rhs_q[ACC_W-1]))
                begin
                    num_next = rhs_q[ACC_W-1] ? A_MIN : A_MAX;
                    err_next = 1'b1;
                end
                else
                begin
                    num_next = sub_d;
                end
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                nmag_next  = num_reg[ACC_W-1] ? (ACC_W'(0) - num_reg) : num_reg;
                dmag_next  = diag_reg[COEF_W-1] ? (COEF_W'(0) - diag_reg) : diag_reg;
                neg_next   = num_reg[ACC_W-1] != diag_reg[COEF_W-1];
                dzero_next = (diag_reg == '0);
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (dzero_reg)
                begin
                    x_next     = num_reg[ACC_W-1] ? Q_MIN : Q_MAX;
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (nmag_reg[ACC_W-1:COEF_W] >= dmag_reg)
                begin
                    // quotient needs more than 32 bits
                    x_next     = neg_reg ? Q_MIN : Q_MAX;
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    rem_next   = nmag_reg[ACC_W-1:COEF_W];
                    quo_next   = nmag_reg[COEF_W-1:0];
                    cnt_next   = CNT_W'(COEF_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? COEF_W'(div_t - {1'b0, dmag_reg}) : div_t[COEF_W-1:0];
                quo_next = {quo_reg[COEF_W-2:0], div_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (neg_reg)
                begin
                    if (quo_reg > Q_MIN)
                    begin
                        x_next   = Q_MIN;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        x_next = COEF_W'(0) - quo_reg;
                    end
                end
                else
                begin
                    if (quo_reg > Q_MAX)
                    begin
                        x_next   = Q_MAX;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        x_next = quo_reg;
                    end
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    osol_next  = x_reg;
                    orow_next  = row_ext[ROW_OUT_W-1:0];
                    oerr_next  = err_reg;
                    olast_next = row_last;
                    row_next   = row_last ? '0 : ROW_W'(row_inc);
                    col_next   = '0;
                    sum_next   = '0;
                    sovf_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            order_reg    <= ORDER_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            sum_reg      <= '0;
            sovf_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= cfg_data;
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            sum_reg      <= sum_next;
            sovf_reg     <= sovf_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            ov_reg       <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_coef_reg <= s1_coef_next;
        prod_reg    <= prod_next;
        diag_reg    <= diag_next;
        rhs_reg     <= rhs_next;
        num_reg     <= num_next;
        err_reg     <= err_next;
        nmag_reg    <= nmag_next;
        dmag_reg    <= dmag_next;
        neg_reg     <= neg_next;
        dzero_reg   <= dzero_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        osol_reg    <= osol_next;
        orow_reg    <= orow_next;
        oerr_reg    <= oerr_next;
        olast_reg   <= olast_next;
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the forward-substitution solver against its own Q16.16 predictor.
// Directed rows drive the saturation corners. Random systems then run under
// several order settings while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import ltfs_pkg::*;

    localparam int HOLD_CYCLES = 50;     // covers the diagonal path
    localparam int IDLE_LIMIT  = 4000;
    localparam int N_PHASES    = 9;
    localparam int N_DIRECTED  = 24;

    // order settings per phase and how many rows each phase sends
    localparam logic [CFG_W-1:0] PHASE_ORDER [N_PHASES] =
        '{7'd0, 7'd1, 7'd3, 7'd127, 7'd7, 7'd2, 7'd64, 7'd12, 7'd5};
    localparam int PHASE_ROWS [N_PHASES] = '{4, 3, 8, 70, 10, 5, 10, 13, 12};

    // directed rows: saturating and zero diagonals, sum overflow both ways,
    // too few and too many coefficients, quotient at the 32-bit edge
    localparam logic [31:0] DIR_COEF [N_DIRECTED] = '{
        32'h0000_0001,
        32'h8000_0000, 32'h0000_0000,
        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000,
        32'h0000_0000,
        32'h0000_0000,
        32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
        32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
        32'h0001_0000,
        32'hFFFF_0000,
        32'h8000_0000};
    localparam logic [31:0] DIR_RHS [N_DIRECTED] = '{
        32'h8000_0000,
        32'h5A5A_5A5A, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
        32'hA5A5_A5A5, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_FFFF,
        32'h0001_0000,
        32'h0000_0000,
        32'h1111_1111, 32'h2222_2222, 32'h4444_4444, 32'h8888_8888,
        32'hCCCC_CCCC, 32'h3333_3333, 32'h7777_7777, 32'hEEEE_EEEE, 32'h0000_0000,
        32'h8000_0000,
        32'h8000_0000,
        32'h7FFF_FFFF};
    localparam bit DIR_END [N_DIRECTED] = '{
        1,
        0, 1,
        0, 0, 1,
        0, 0, 0, 1,
        1,
        1,
        0, 0, 0, 0, 0, 0, 0, 0, 1,
        1,
        1,
        1};

    typedef struct {
        logic [COEF_W-1:0]    solution;
        logic [ROW_OUT_W-1:0] row;
        bit                   err;
        bit                   last;
    } solution_t;

    class solve_scoreboard;
        logic signed [COEF_W-1:0] store [DEFAULT_MAX_ORDER];
        logic signed [ACC_W-1:0]  acc;
        bit                       acc_sat;
        int unsigned              row_idx;
        int unsigned              col_idx;
        logic [CFG_W-1:0]         order_reg;
        solution_t                pending_q[$];
        int                       mismatches;
        int                       items;
        int                       solved;
        int                       flagged;
        int                       wraps;

        function new();
            foreach (store[i])
                store[i] = '0;
            acc        = '0;
            acc_sat    = 1'b0;
            row_idx    = 0;
            col_idx    = 0;
            order_reg  = ORDER_RESET;
            mismatches = 0;
            items      = 0;
            solved     = 0;
            flagged    = 0;
            wraps      = 0;
        endfunction

        function int unsigned active_order();
            if (order_reg == 0)
                return 1;
            if (order_reg > DEFAULT_MAX_ORDER)
                return DEFAULT_MAX_ORDER;
            return order_reg;
        endfunction

        // clamp a 65-bit result to the signed 64-bit range
        function logic signed [ACC_W-1:0] clamp65(logic signed [ACC_W:0] wide, inout bit ovf);
            if (wide[ACC_W] != wide[ACC_W-1])
            begin
                ovf = 1'b1;
                return wide[ACC_W] ? A_MIN : A_MAX;
            end
            return wide[ACC_W-1:0];
        endfunction

        function void note_input(logic [COEF_W-1:0] coef, logic [COEF_W-1:0] rhs, bit ends);
            logic signed [ACC_W-1:0] c64;
            logic signed [ACC_W-1:0] s64;
            logic signed [ACC_W-1:0] prod;
            logic signed [ACC_W-1:0] num;
            logic [ACC_W-1:0]        nmag;
            logic [ACC_W-1:0]        dmag;
            logic [ACC_W-1:0]        quo;
            logic [COEF_W-1:0]       x;
            int unsigned             row;
            bit                      err;
            bit                      last;

            items++;
            row = (row_idx >= DEFAULT_MAX_ORDER) ? DEFAULT_MAX_ORDER - 1 : row_idx;
            c64 = $signed(coef);
            if (!ends)
            begin
                // extra coefficients past the diagonal column are dropped
                if (col_idx < row)
                begin
                    s64  = store[col_idx];
                    prod = c64 * s64;
                    acc  = clamp65({acc[ACC_W-1], acc} + {prod[ACC_W-1], prod}, acc_sat);
                    col_idx++;
                end
                return;
            end

            err = acc_sat;
            num = clamp65({{17{rhs[COEF_W-1]}}, rhs, 16'h0000} - {acc[ACC_W-1], acc}, err);
            if (coef == '0)
            begin
                err = 1'b1;
                x   = num[ACC_W-1] ? Q_MIN : Q_MAX;
            end
            else
            begin
                nmag = num[ACC_W-1] ? -num : num;
                dmag = c64[ACC_W-1] ? -c64 : c64;
                quo  = nmag / dmag;
                if (num[ACC_W-1] ^ coef[COEF_W-1])
                begin
                    if (quo > 64'h0000_0000_8000_0000)
                    begin
                        err = 1'b1;
                        x   = Q_MIN;
                    end
                    else
                        x = '0 - quo[COEF_W-1:0];
                end
                else
                begin
                    if (quo > 64'h0000_0000_7FFF_FFFF)
                    begin
                        err = 1'b1;
                        x   = Q_MAX;
                    end
                    else
                        x = quo[COEF_W-1:0];
                end
            end

            last       = (row + 1 >= active_order());
            store[row] = x;
            pending_q.push_back('{x, ROW_OUT_W'(row), err, last});
            acc     = '0;
            col_idx = 0;
            acc_sat = 1'b0;
            row_idx = last ? 0 : row + 1;
        endfunction

        task report(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            // keep the log bounded if everything goes wrong
            if (mismatches <= 50)
                $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
        endtask

        task check_result(logic [COEF_W-1:0] sol, logic [ROW_OUT_W-1:0] rown, bit err, bit last);
            solution_t want;
            if (pending_q.size() == 0)
            begin
                report("unexpected result", '0, sol);
                return;
            end
            want = pending_q.pop_front();
            solved++;
            if (want.err)
                flagged++;
            if (want.last)
                wraps++;
            if (sol !== want.solution)
                report("solution", want.solution, sol);
            if (rown !== want.row)
                report("row_number", want.row, rown);
            if (err !== want.err)
                report("error_flag", want.err, err);
            if (last !== want.last)
                report("last_row", want.last, last);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    solve_scoreboard sb = new();
    int              burst_left = 0;
    bit              steady = 1'b0;
    int              idle_cycles = 0;

    lower_triangular_forward_solve_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: segments of always-ready, coin-flip and mostly-stalled
    initial
    begin
        int unsigned seg_left;
        int unsigned mode;
        m_axis_tready = 1'b0;
        seg_left      = 0;
        mode          = 0;
        forever
        begin
            @(negedge clk);
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(1, 48);
            end
            seg_left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tuser, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(logic [31:0] coef, logic [31:0] rhs, bit ends);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = steady ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rhs, coef};
        s_axis_tlast  <= ends;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(coef, rhs, ends);
        // now and then hold off until the output side is empty
        if (sb.items % 97 == 0)
            drain_results();
    endtask

    task automatic write_order(logic [CFG_W-1:0] value);
        drain_results();
        repeat (HOLD_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.order_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one row: mostly well formed, sometimes short or padded; long rows are
    // cut short so high orders stay cheap
    task automatic run_row();
        int unsigned cur;
        int unsigned n;
        int unsigned pick;
        logic [31:0] c;
        logic [31:0] v;
        cur  = sb.row_idx;
        n    = (cur <= 6) ? cur : $urandom_range(0, 3);
        pick = $urandom_range(0, 99);
        if (pick < 8 && n > 0)
            n = $urandom_range(0, n - 1);
        else if (pick < 16)
            n = n + $urandom_range(1, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                c = $urandom();
            else
                c = 32'(int'($urandom_range(0, 32'h8000)) - 32'h4000);
            send_item(c, $urandom(), 1'b0);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            c = '0;
        else if (pick == 1)
            c = $urandom();
        else
        begin
            c = $urandom_range(32'h8000, 32'h40000);
            if ($urandom_range(0, 1) == 1)
                c = '0 - c;
        end
        if ($urandom_range(0, 7) == 0)
            v = $urandom();
        else
            v = 32'(int'($urandom_range(0, 32'h200000)) - 32'h100000);
        send_item(c, v, 1'b1);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIR_COEF[i], DIR_RHS[i], DIR_END[i]);

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_order(PHASE_ORDER[p]);
            steady = (p % 3 == 2);
            for (int r = 0; r < PHASE_ROWS[p]; r++)
                run_row();
        end

        drain_results();
        repeat (HOLD_CYCLES) @(posedge clk);
        $display("ran %0d input transactions and %0d solutions over %0d order settings",
                 sb.items, sb.solved, N_PHASES + 1);
        $display("%0d solutions carried the error flag, %0d closed a system",
                 sb.flagged, sb.wraps);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ lower_triangular_forward_solve_top.f @@
design/ltfs_pkg.sv
design/ltfs_ram.sv
design/lower_triangular_forward_solve_top.sv
test/testbench.sv
